// File: rtl/sldrv_pkg.sv
// ----------------------------------------------------------------------------
// sldrv_pkg: shared types and constants
// Request and response payloads, the CSR bank, the update state and the
// blink-pattern table of the status LED driver.
// ----------------------------------------------------------------------------
`default_nettype none

package sldrv_pkg;

   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLID_LEVEL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_INTERVAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_ENABLE   = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_ERROR  = 2'd0;
   localparam logic [1:0] STATUS_GREEN  = 2'd1;
   localparam logic [1:0] STATUS_YELLOW = 2'd2;
   localparam logic [1:0] STATUS_RED    = 2'd3;

   // error code with its own all-LED toggle display
   localparam logic [3:0] CODE_BUF_EXHAUSTED = 4'd7;

   // pattern entries
   localparam logic [1:0] ENTRY_END    = 2'd0;
   localparam logic [1:0] ENTRY_GREEN  = 2'd1;
   localparam logic [1:0] ENTRY_YELLOW = 2'd2;
   localparam logic [1:0] ENTRY_RED    = 2'd3;

   localparam logic [TIME_W-1:0] TOGGLE_MS = 32'd300;
   localparam logic [TIME_W-1:0] STEP_MS   = 32'd500;
   localparam logic [TIME_W-1:0] PAUSE_MS  = 32'd3000;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST      = 8'd255;
   localparam logic [LEVEL_W-1:0] SOLID_LEVEL_RST    = 8'd128;
   localparam logic [15:0]        PULSE_INTERVAL_RST = 16'd20;
   localparam logic [LEVEL_W-1:0] PULSE_STEP_RST     = 8'd5;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              quiet;
      logic              snoozed;
      logic [1:0]        status;
      logic [3:0]        error_code;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] yellow_level;
      logic [LEVEL_W-1:0] red_level;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] max_level;
      logic [LEVEL_W-1:0] solid_level;
      logic [15:0]        pulse_interval_ms;
      logic [LEVEL_W-1:0] pulse_step;
      logic               flash_enable;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  pulse_last_time;
      logic [LEVEL_W-1:0] pulse_level;
      logic               pulse_rising;
      logic [TIME_W-1:0]  flash_last_time;
      logic [1:0]         pattern_step;
      logic               pausing;
      logic [TIME_W-1:0]  pause_start;
      logic               all_on;
      rsp_type            drive;
   } state_type;

   // six blink patterns, four entries each; the last entry always ends it
   function automatic logic [1:0] pattern_entry(input logic [2:0] idx,
                                                input logic [1:0] step);
      logic [7:0] row;
      begin
         case (idx)
            3'd0:    row = {ENTRY_END, ENTRY_RED,    ENTRY_END,    ENTRY_RED};
            3'd1:    row = {ENTRY_END, ENTRY_END,    ENTRY_RED,    ENTRY_YELLOW};
            3'd2:    row = {ENTRY_END, ENTRY_RED,    ENTRY_YELLOW, ENTRY_RED};
            3'd3:    row = {ENTRY_END, ENTRY_END,    ENTRY_YELLOW, ENTRY_GREEN};
            3'd4:    row = {ENTRY_END, ENTRY_RED,    ENTRY_RED,    ENTRY_RED};
            3'd5:    row = {ENTRY_END, ENTRY_YELLOW, ENTRY_GREEN,  ENTRY_YELLOW};
            default: row = {ENTRY_END, ENTRY_END,    ENTRY_END,    ENTRY_END};
         endcase
         return row[{step, 1'b0} +: 2];
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/sldrv_csr.sv
// ----------------------------------------------------------------------------
// sldrv_csr: configuration register bank
// Five write-only control registers, loaded from the CSR write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sldrv_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [sldrv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sldrv_pkg::CSR_DATA_W-1:0]  csr_data,
   output sldrv_pkg::cfg_type                     cfg
);

   sldrv_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sldrv_pkg::CSR_MAX_LEVEL:      cfg_in.max_level         = csr_data[7:0];
            sldrv_pkg::CSR_SOLID_LEVEL:    cfg_in.solid_level       = csr_data[7:0];
            sldrv_pkg::CSR_PULSE_INTERVAL: cfg_in.pulse_interval_ms = csr_data;
            sldrv_pkg::CSR_PULSE_STEP:     cfg_in.pulse_step        = csr_data[7:0];
            sldrv_pkg::CSR_FLASH_ENABLE:   cfg_in.flash_enable      = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_level         <= sldrv_pkg::MAX_LEVEL_RST;
         cfg_ff.solid_level       <= sldrv_pkg::SOLID_LEVEL_RST;
         cfg_ff.pulse_interval_ms <= sldrv_pkg::PULSE_INTERVAL_RST;
         cfg_ff.pulse_step        <= sldrv_pkg::PULSE_STEP_RST;
         cfg_ff.flash_enable      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/sldrv_update.sv
// ----------------------------------------------------------------------------
// sldrv_update: one LED update
// Next state and drive levels from the registered request, the current
// state and the CSRs. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module sldrv_update (
   input  wire sldrv_pkg::req_type    req,
   input  wire sldrv_pkg::cfg_type    cfg,
   input  wire sldrv_pkg::state_type  cur,
   output sldrv_pkg::state_type       nxt
);

   logic [7:0]        solid_val;
   logic [2:0]        pat_idx;
   logic [1:0]        entry;
   logic              toggle_due;
   logic              step_due;
   logic              pause_done;
   logic              pulse_due;
   logic signed [9:0] pulse_sum;
   logic signed [9:0] max_ext;
   logic              flashing;

   assign solid_val = (cfg.solid_level < cfg.max_level) ? cfg.solid_level : cfg.max_level;

   assign pat_idx = (req.error_code >= 4'd1 && req.error_code <= 4'd6)
                    ? 3'(req.error_code - 4'd1) : 3'd0;
   assign entry   = sldrv_pkg::pattern_entry(pat_idx, cur.pattern_step);

   assign toggle_due = (req.now_ms - cur.flash_last_time) >= sldrv_pkg::TOGGLE_MS;
   assign step_due   = (req.now_ms - cur.flash_last_time) >= sldrv_pkg::STEP_MS;
   assign pause_done = (req.now_ms - cur.pause_start) >= sldrv_pkg::PAUSE_MS;
   assign pulse_due  = (req.now_ms - cur.pulse_last_time) >= {16'd0, cfg.pulse_interval_ms};

   assign pulse_sum = cur.pulse_rising
                      ? $signed({2'b00, cur.pulse_level}) + $signed({2'b00, cfg.pulse_step})
                      : $signed({2'b00, cur.pulse_level}) - $signed({2'b00, cfg.pulse_step});
   assign max_ext   = $signed({2'b00, cfg.max_level});

   assign flashing = cfg.flash_enable && req.status[1];

   always_comb begin
      nxt = cur;
      if (req.quiet) begin
         nxt.drive = '0;
      end else if (req.snoozed) begin
         nxt.drive             = '0;
         nxt.drive.green_level = solid_val;
      end else if (req.status == sldrv_pkg::STATUS_ERROR) begin
         if (req.error_code == sldrv_pkg::CODE_BUF_EXHAUSTED) begin
            if (toggle_due) begin
               nxt.flash_last_time = req.now_ms;
               nxt.all_on          = ~cur.all_on;
               nxt.drive.green_level  = cur.all_on ? 8'd0 : cfg.max_level;
               nxt.drive.yellow_level = cur.all_on ? 8'd0 : cfg.max_level;
               nxt.drive.red_level    = cur.all_on ? 8'd0 : cfg.max_level;
            end
         end else if (cur.pausing) begin
            nxt.drive = '0;
            if (pause_done) begin
               nxt.pausing      = 1'b0;
               nxt.pattern_step = 2'd0;
            end
         end else if (step_due) begin
            nxt.flash_last_time = req.now_ms;
            nxt.drive           = '0;
            nxt.pattern_step    = cur.pattern_step + 2'd1;
            case (entry)
               sldrv_pkg::ENTRY_GREEN:  nxt.drive.green_level  = cfg.max_level;
               sldrv_pkg::ENTRY_YELLOW: nxt.drive.yellow_level = cfg.max_level;
               sldrv_pkg::ENTRY_RED:    nxt.drive.red_level    = cfg.max_level;
               default: begin
                  // end of pattern: start the long off period
                  nxt.pausing      = 1'b1;
                  nxt.pause_start  = req.now_ms;
                  nxt.pattern_step = 2'd0;
               end
            endcase
         end
      end else if (flashing) begin
         nxt.drive = '0;
         if (pulse_due) begin
            nxt.pulse_last_time = req.now_ms;
            if (pulse_sum >= max_ext) begin
               nxt.pulse_level  = cfg.max_level;
               nxt.pulse_rising = 1'b0;
            end else if (pulse_sum <= 10'sd0) begin
               nxt.pulse_level  = 8'd0;
               nxt.pulse_rising = 1'b1;
            end else begin
               nxt.pulse_level = pulse_sum[7:0];
            end
         end
         if (req.status == sldrv_pkg::STATUS_RED) begin
            nxt.drive.red_level = nxt.pulse_level;
         end else begin
            nxt.drive.yellow_level = nxt.pulse_level;
         end
      end else begin
         nxt.drive = '0;
         case (req.status)
            sldrv_pkg::STATUS_RED:    nxt.drive.red_level    = solid_val;
            sldrv_pkg::STATUS_YELLOW: nxt.drive.yellow_level = solid_val;
            default:                  nxt.drive.green_level  = solid_val;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/status_led_blink_code_driver.sv
// ----------------------------------------------------------------------------
// status_led_blink_code_driver: status LED blink-code driver
// Turns timed status updates into green, yellow and red drive levels with
// blink codes, pulsing and solid display.
// ----------------------------------------------------------------------------
//  channel | direction | payload               | handshake
//  req_    | in        | sldrv_pkg::req_type   | req_valid / req_ready
//  rsp_    | out       | sldrv_pkg::rsp_type   | rsp_valid / rsp_ready
//  csr_    | in        | csr_index, csr_data   | csr_valid / csr_ready
//
//  One request per cycle sustained while rsp_ready is held; a response is valid once
//  its request has passed the input register, then the state/response register.
//  The update logic runs in the cycle the input register moves to the output.
//  Synchronous reset loads the reset state and the CSR defaults; csr_ready is 1.
//  A stalled response holds the pipe; the input register still takes one more.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_blink_code_driver (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire sldrv_pkg::req_type                req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output sldrv_pkg::rsp_type                     rsp_data,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [sldrv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sldrv_pkg::CSR_DATA_W-1:0]  csr_data
);

   sldrv_pkg::cfg_type   cfg;
   sldrv_pkg::req_type   in_data_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sldrv_pkg::state_type state_ff, state_in;
   sldrv_pkg::state_type state_rst;
   logic                 advance;

   assign csr_ready = 1'b1;

   // everything starts at zero except the pulse direction, which starts rising
   always_comb begin
      state_rst              = '0;
      state_rst.pulse_rising = 1'b1;
   end

   sldrv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sldrv_update u_update (
      .req (in_data_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_in)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= state_rst;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // drive levels in the state register are the last response
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = state_ff.drive;

endmodule

`default_nettype wire
